FILE: rtl/text_mode_terminal_writer_defines.svh
// Assertion macros of the terminal writer, used by the back-end module ttw_back.
// Both macros sample on the rising edge of clk and are disabled while arst_n is low.
`ifndef TEXT_MODE_TERMINAL_WRITER_DEFINES_SVH
`define TEXT_MODE_TERMINAL_WRITER_DEFINES_SVH

// Same-cycle implication: whenever ante holds, cons must hold too.
`define TTW_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication: whenever ante holds, cons must hold in the next cycle.
`define TTW_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/ttw_pkg.sv
`timescale 1ns / 1ps
package ttw_pkg;

	// Screen geometry.
	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;
	localparam int CELLS   = ROWS * COLUMNS;

	localparam int COL_W  = $clog2(COLUMNS);
	localparam int ROW_W  = $clog2(ROWS);
	localparam int ADDR_W = $clog2(CELLS);

	// Fixed field widths of the words on the ports.
	localparam int CMD_W  = 2;
	localparam int CHAR_W = 8;
	localparam int IDX_W  = 11;
	localparam int POS_W  = 11;
	localparam int CELL_W = 16;
	localparam int COLOR_W = 8;

	// Depth of the queue between the front and the back.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

	// Character codes with a meaning of their own.
	localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
	localparam logic [CHAR_W-1:0] CH_BLANK     = 8'h20;

	// Reset value of the text color register.
	localparam logic [COLOR_W-1:0] COLOR_RESET = 8'h07;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [CHAR_W-1:0] char_code;
		logic [IDX_W-1:0]  cell_index;
	} ttw_in_t;

	typedef struct packed {
		logic [POS_W-1:0]  cursor_position;
		logic [CELL_W-1:0] cell_data;
		logic              scrolled;
	} ttw_out_t;

	// Operation kinds after classification in the front.
	typedef enum logic [2:0] {
		OP_CHAR,
		OP_NEWLINE,
		OP_BACKSPACE,
		OP_CLEAR,
		OP_READ,
		OP_NOP
	} ttw_op_t;

	typedef struct packed {
		ttw_op_t           kind;
		logic [CHAR_W-1:0] char_code;
		logic [IDX_W-1:0]  cell_index;
		logic              idx_ok;
	} ttw_op_word_t;

	// Back-end sequencer states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_READ_WAIT,
		S_SCROLL_COPY,
		S_SCROLL_BLANK,
		S_CLEAR,
		S_RESULT
	} ttw_state_t;

endpackage

FILE: rtl/ttw_front.sv
`timescale 1ns / 1ps
module ttw_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  ttw_pkg::ttw_in_t      in_word,
	output logic                  enq_valid,
	input  logic                  enq_full,
	output ttw_pkg::ttw_op_word_t enq_word
);
	import ttw_pkg::*;

	logic         valid_s1;
	ttw_op_word_t word_s1;
	ttw_op_word_t cls_word;
	logic         accept;
	logic         move;

	// Decode the command and character into one operation kind.
	always_comb begin
		cls_word.char_code  = in_word.char_code;
		cls_word.cell_index = in_word.cell_index;
		cls_word.idx_ok     = (int'(in_word.cell_index) < CELLS);
		case (in_word.command)
			CMD_PUT: begin
				if (in_word.char_code == CH_NEWLINE) begin
					cls_word.kind = OP_NEWLINE;
				end else if (in_word.char_code == CH_BACKSPACE) begin
					cls_word.kind = OP_BACKSPACE;
				end else begin
					cls_word.kind = OP_CHAR;
				end
			end
			CMD_CLEAR: cls_word.kind = OP_CLEAR;
			CMD_READ:  cls_word.kind = OP_READ;
			default:   cls_word.kind = OP_NOP;
		endcase
	end

	// The stage empties into the queue whenever the queue has room.
	assign move      = valid_s1 && !enq_full;
	assign full      = valid_s1 && enq_full;
	assign accept    = push && !full;
	assign enq_valid = valid_s1;
	assign enq_word  = word_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1 <= cls_word;
		end
	end

endmodule

FILE: rtl/ttw_queue.sv
`timescale 1ns / 1ps
module ttw_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  enq_valid,
	output logic                  enq_full,
	input  ttw_pkg::ttw_op_word_t enq_word,
	output logic                  deq_valid,
	input  logic                  deq,
	output ttw_pkg::ttw_op_word_t deq_word
);
	import ttw_pkg::*;

	localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);
	localparam logic [QCNT_W-1:0] CNT_FULL = QCNT_W'(QUEUE_DEPTH);

	ttw_op_word_t        entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                do_enq;
	logic                do_deq;

	assign enq_full  = (count_q == CNT_FULL);
	assign deq_valid = (count_q != '0);
	assign deq_word  = entry_q[rd_ptr_q];
	assign do_enq    = enq_valid && !enq_full;
	assign do_deq    = deq && deq_valid;

	// Pointers and fill count; pointers wrap at the queue depth.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_enq) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : QPTR_W'(wr_ptr_q + 1'b1);
			end
			if (do_deq) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : QPTR_W'(rd_ptr_q + 1'b1);
			end
			if (do_enq && !do_deq) begin
				count_q <= QCNT_W'(count_q + 1'b1);
			end else if (do_deq && !do_enq) begin
				count_q <= QCNT_W'(count_q - 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_enq) begin
			entry_q[wr_ptr_q] <= enq_word;
		end
	end

endmodule

FILE: rtl/ttw_back.sv
`timescale 1ns / 1ps
`include "text_mode_terminal_writer_defines.svh"
module ttw_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       deq_valid,
	output logic                       deq,
	input  ttw_pkg::ttw_op_word_t      deq_word,
	input  logic                       text_color_we,
	input  logic [ttw_pkg::COLOR_W-1:0] text_color,
	output logic                       empty,
	input  logic                       pop,
	output ttw_pkg::ttw_out_t          out_word
);
	import ttw_pkg::*;

	localparam logic [COL_W-1:0]  COL_LAST     = COL_W'(COLUMNS - 1);
	localparam logic [ROW_W-1:0]  ROW_LAST     = ROW_W'(ROWS - 1);
	localparam logic [ADDR_W-1:0] CELL_LAST    = ADDR_W'(CELLS - 1);
	localparam logic [ADDR_W-1:0] COPY_LAST    = ADDR_W'(CELLS - COLUMNS - 1);
	localparam logic [ADDR_W-1:0] BOTTOM_FIRST = ADDR_W'(CELLS - COLUMNS);
	localparam logic [ADDR_W-1:0] ROW_STRIDE   = ADDR_W'(COLUMNS);

	ttw_state_t          state_q, state_d;
	ttw_op_word_t        op_q;
	logic [ROW_W-1:0]    row_q, row_d;
	logic [COL_W-1:0]    col_q, col_d;
	logic [ADDR_W-1:0]   cnt_q, cnt_d;
	logic                cp_valid_q, cp_valid_d;
	logic [ADDR_W-1:0]   cp_addr_q, cp_addr_d;
	logic [CELL_W-1:0]   data_q, data_d;
	logic                scr_q, scr_d;
	logic [COLOR_W-1:0]  color_q;
	ttw_out_t            res_q;
	logic                res_valid_q;
	logic                res_load;

	logic [CELL_W-1:0]   mem [CELLS];
	logic [CELL_W-1:0]   rd_q;
	logic                mem_we;
	logic [ADDR_W-1:0]   mem_waddr;
	logic [CELL_W-1:0]   mem_wdata;
	logic                mem_re;
	logic [ADDR_W-1:0]   mem_raddr;

	logic [ADDR_W-1:0]   lin_addr;
	logic [CELL_W-1:0]   blank_cell;
	logic                at_home;

	// Linear cell address of the cursor and the blank cell in the current color.
	assign lin_addr   = ADDR_W'(ADDR_W'(row_q) * ROW_STRIDE) + ADDR_W'(col_q);
	assign blank_cell = {color_q, CH_BLANK};
	assign at_home    = (row_q == '0) && (col_q == '0);

	// Screen memory: one write port and one registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_q <= mem[mem_raddr];
		end
	end

	// Next state, cursor update and memory port control.
	always_comb begin
		state_d    = state_q;
		row_d      = row_q;
		col_d      = col_q;
		cnt_d      = cnt_q;
		cp_valid_d = 1'b0;
		cp_addr_d  = cp_addr_q;
		data_d     = data_q;
		scr_d      = scr_q;
		deq        = 1'b0;
		res_load   = 1'b0;
		mem_re     = 1'b0;
		mem_raddr  = cnt_q;
		mem_we     = 1'b0;
		mem_waddr  = cnt_q;
		mem_wdata  = blank_cell;

		// A copy read during scrolling lands in the next cycle; it owns the write port.
		if (cp_valid_q) begin
			mem_we    = 1'b1;
			mem_waddr = cp_addr_q;
			mem_wdata = rd_q;
		end

		case (state_q)
			S_IDLE: begin
				if (deq_valid) begin
					deq     = 1'b1;
					data_d  = '0;
					scr_d   = 1'b0;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_RESULT;
				case (op_q.kind)
					OP_CHAR: begin
						mem_we    = 1'b1;
						mem_waddr = lin_addr;
						mem_wdata = {color_q, op_q.char_code};
						if (col_q == COL_LAST) begin
							col_d = '0;
							if (row_q == ROW_LAST) begin
								scr_d   = 1'b1;
								cnt_d   = '0;
								state_d = S_SCROLL_COPY;
							end else begin
								row_d = ROW_W'(row_q + 1'b1);
							end
						end else begin
							col_d = COL_W'(col_q + 1'b1);
						end
					end
					OP_NEWLINE: begin
						col_d = '0;
						if (row_q == ROW_LAST) begin
							scr_d   = 1'b1;
							cnt_d   = '0;
							state_d = S_SCROLL_COPY;
						end else begin
							row_d = ROW_W'(row_q + 1'b1);
						end
					end
					OP_BACKSPACE: begin
						// The cell before the cursor is one lower in linear order.
						mem_we    = 1'b1;
						mem_waddr = at_home ? lin_addr : ADDR_W'(lin_addr - 1'b1);
						mem_wdata = blank_cell;
						if (col_q != '0) begin
							col_d = COL_W'(col_q - 1'b1);
						end else if (row_q != '0) begin
							row_d = ROW_W'(row_q - 1'b1);
							col_d = COL_LAST;
						end
					end
					OP_CLEAR: begin
						row_d   = '0;
						col_d   = '0;
						cnt_d   = '0;
						state_d = S_CLEAR;
					end
					OP_READ: begin
						if (op_q.idx_ok) begin
							mem_re    = 1'b1;
							mem_raddr = ADDR_W'(op_q.cell_index);
							state_d   = S_READ_WAIT;
						end
					end
					default: begin
						state_d = S_RESULT;
					end
				endcase
			end
			S_READ_WAIT: begin
				data_d  = rd_q;
				state_d = S_RESULT;
			end
			S_SCROLL_COPY: begin
				// Read one row below, write back from the previous read.
				mem_re     = 1'b1;
				mem_raddr  = ADDR_W'(cnt_q + ROW_STRIDE);
				cp_valid_d = 1'b1;
				cp_addr_d  = cnt_q;
				if (cnt_q == COPY_LAST) begin
					cnt_d   = BOTTOM_FIRST;
					state_d = S_SCROLL_BLANK;
				end else begin
					cnt_d = ADDR_W'(cnt_q + 1'b1);
				end
			end
			S_SCROLL_BLANK: begin
				// Wait while the last copy write drains, then blank the bottom row.
				if (!cp_valid_q) begin
					mem_we    = 1'b1;
					mem_waddr = cnt_q;
					mem_wdata = blank_cell;
					if (cnt_q == CELL_LAST) begin
						state_d = S_RESULT;
					end else begin
						cnt_d = ADDR_W'(cnt_q + 1'b1);
					end
				end
			end
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = cnt_q;
				mem_wdata = blank_cell;
				if (cnt_q == CELL_LAST) begin
					state_d = S_RESULT;
				end else begin
					cnt_d = ADDR_W'(cnt_q + 1'b1);
				end
			end
			S_RESULT: begin
				if (!res_valid_q || pop) begin
					res_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			row_q       <= '0;
			col_q       <= '0;
			cnt_q       <= '0;
			cp_valid_q  <= 1'b0;
			scr_q       <= 1'b0;
			color_q     <= COLOR_RESET;
			res_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			row_q      <= row_d;
			col_q      <= col_d;
			cnt_q      <= cnt_d;
			cp_valid_q <= cp_valid_d;
			scr_q      <= scr_d;
			if (text_color_we) begin
				color_q <= text_color;
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (pop) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		cp_addr_q <= cp_addr_d;
		data_q    <= data_d;
		if (deq) begin
			op_q <= deq_word;
		end
		if (res_load) begin
			res_q.cursor_position <= POS_W'(lin_addr);
			res_q.cell_data       <= data_q;
			res_q.scrolled        <= scr_q;
		end
	end

	assign empty    = !res_valid_q;
	assign out_word = res_q;

	// Checks on the sequencer and the memory port.
	`TTW_ASSERT_IMPLY(a_cursor_in_range, 1'b1, (row_q <= ROW_LAST) && (col_q <= COL_LAST), "cursor left the screen")
	`TTW_ASSERT_IMPLY(a_write_in_range, mem_we, mem_waddr <= CELL_LAST, "screen write out of range")
	`TTW_ASSERT_IMPLY(a_scroll_last_row, (state_q == S_RESULT) && scr_q, row_q == ROW_LAST, "scroll left cursor off the last row")
	`TTW_ASSERT_IMPLY(a_copy_in_scroll, cp_valid_q, (state_q == S_SCROLL_COPY) || (state_q == S_SCROLL_BLANK), "copy write outside scrolling")
	`TTW_ASSERT_NEXT(a_copy_to_blank, (state_q == S_SCROLL_COPY) && (cnt_q == COPY_LAST), (state_q == S_SCROLL_BLANK) && cp_valid_q, "copy pass did not hand over to blanking")

endmodule

FILE: rtl/text_mode_terminal_writer.sv
`timescale 1ns / 1ps
// Character-cell text screen writer with a 25 x 80 screen of 16-bit cells (attribute high,
// character low) and a row/column cursor. Words enter through push/full, pass a classify
// stage and a two-entry queue, and are carried out by a sequencer that owns the screen
// memory with its one write port and one registered read port; results leave through
// empty/pop from an output register, so up to four words can be taken in while a result
// waits. A word that scrolls the screen moves every row but the top one row up and then
// blanks the bottom row once the last copy write has drained, and a clear blanks every
// cell; both go one cell at a time through the one write port of the screen memory. The
// screen is undefined until it is cleared or written, and text_color may be written only
// while the block is idle.
module text_mode_terminal_writer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  ttw_pkg::ttw_in_t            in_word,
	output logic                        empty,
	input  logic                        pop,
	output ttw_pkg::ttw_out_t           out_word,
	input  logic                        text_color_we,
	input  logic [ttw_pkg::COLOR_W-1:0] text_color
);
	import ttw_pkg::*;

	logic         enq_valid;
	logic         enq_full;
	ttw_op_word_t enq_word;
	logic         deq_valid;
	logic         deq;
	ttw_op_word_t deq_word;

	// Front: accept and classify.
	ttw_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.in_word   (in_word),
		.enq_valid (enq_valid),
		.enq_full  (enq_full),
		.enq_word  (enq_word)
	);

	// Short queue between front and back.
	ttw_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.enq_valid (enq_valid),
		.enq_full  (enq_full),
		.enq_word  (enq_word),
		.deq_valid (deq_valid),
		.deq       (deq),
		.deq_word  (deq_word)
	);

	// Back: screen memory, cursor and result register.
	ttw_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.deq_valid     (deq_valid),
		.deq           (deq),
		.deq_word      (deq_word),
		.text_color_we (text_color_we),
		.text_color    (text_color),
		.empty         (empty),
		.pop           (pop),
		.out_word      (out_word)
	);

endmodule

FILE: tb/terminal_screen_checker.sv
`timescale 1ns / 1ps
// Watches both word channels of the terminal writer, keeps its own copy of the screen,
// the cursor and the text color, and compares every result word with the expected one.
module terminal_screen_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  logic                        full,
	input  ttw_pkg::ttw_in_t            in_word,
	input  logic                        empty,
	input  logic                        pop,
	input  ttw_pkg::ttw_out_t           out_word,
	input  logic                        text_color_we,
	input  logic [ttw_pkg::COLOR_W-1:0] text_color,
	output int                          pending,
	output int                          mismatches
);
	import ttw_pkg::*;

	// Mirror of the block's screen, cursor and color register.
	logic [CELL_W-1:0]  screen [CELLS];
	int                 cur_row;
	int                 cur_col;
	logic [COLOR_W-1:0] active_color;

	// Result words still owed by the block, oldest first.
	ttw_out_t expected_words [$];
	ttw_out_t oldest;

	// Moves the cursor down one row, scrolling at the bottom; returns 1 on a scroll.
	function automatic logic advance_row();
		cur_row++;
		if (cur_row < ROWS) begin
			return 1'b0;
		end
		for (int i = 0; i < CELLS - COLUMNS; i++) begin
			screen[i] = screen[i + COLUMNS];
		end
		for (int i = CELLS - COLUMNS; i < CELLS; i++) begin
			screen[i] = {active_color, CH_BLANK};
		end
		cur_row = ROWS - 1;
		return 1'b1;
	endfunction

	// Carries out one command on the mirror and returns the result word it produces.
	function automatic ttw_out_t apply_command(input ttw_in_t w);
		ttw_out_t r;
		r = '0;
		case (w.command)
			CMD_PUT: begin
				if (w.char_code == CH_NEWLINE) begin
					cur_col = 0;
					r.scrolled = advance_row();
				end else if (w.char_code == CH_BACKSPACE) begin
					if (cur_col > 0) begin
						cur_col--;
					end else if (cur_row > 0) begin
						cur_row--;
						cur_col = COLUMNS - 1;
					end
					screen[cur_row * COLUMNS + cur_col] = {active_color, CH_BLANK};
				end else begin
					screen[cur_row * COLUMNS + cur_col] = {active_color, w.char_code};
					cur_col++;
					if (cur_col >= COLUMNS) begin
						cur_col = 0;
						r.scrolled = advance_row();
					end
				end
			end
			CMD_CLEAR: begin
				for (int i = 0; i < CELLS; i++) begin
					screen[i] = {active_color, CH_BLANK};
				end
				cur_row = 0;
				cur_col = 0;
			end
			CMD_READ: begin
				if (w.cell_index < CELLS) begin
					r.cell_data = screen[w.cell_index];
				end
			end
			default: begin
			end
		endcase
		r.cursor_position = POS_W'(cur_row * COLUMNS + cur_col);
		return r;
	endfunction

	task automatic report_field(input string field, input int unsigned want,
			input logic [31:0] got);
		$display("%0t: %s expected 0x%0h, got 0x%0h", $time, field, want, got);
		mismatches++;
	endtask

	// Results are checked before new words are predicted, since a result accepted at an
	// edge always belongs to an older word.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_words.delete();
			cur_row = 0;
			cur_col = 0;
			active_color = COLOR_RESET;
			mismatches = 0;
			pending <= 0;
		end else begin
			if (pop && !empty) begin
				if (expected_words.size() == 0) begin
					$display("%0t: result word 0x%0h arrived with none expected, got 0x%0h",
						$time, out_word, out_word);
					mismatches++;
				end else begin
					oldest = expected_words.pop_front();
					if (out_word.cursor_position !== oldest.cursor_position) begin
						report_field("cursor_position", oldest.cursor_position,
							out_word.cursor_position);
					end
					if (out_word.cell_data !== oldest.cell_data) begin
						report_field("cell_data", oldest.cell_data, out_word.cell_data);
					end
					if (out_word.scrolled !== oldest.scrolled) begin
						report_field("scrolled", oldest.scrolled, out_word.scrolled);
					end
				end
			end
			if (text_color_we) begin
				active_color = text_color;
			end
			if (push && !full) begin
				expected_words.push_back(apply_command(in_word));
			end
			pending <= expected_words.size();
		end
	end

endmodule

FILE: tb/tb_text_mode_terminal_writer.sv
`timescale 1ns / 1ps
module tb_text_mode_terminal_writer;
	import ttw_pkg::*;

	// Command code the block treats as a no-op.
	localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

	localparam int CYCLE_LIMIT   = 2_000_000;
	localparam int PHASE_WORDS   = 480;
	localparam int MAX_GAP       = 18;
	localparam int HOLD_AT       = 300;
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 16;

	logic               clk;
	logic               arst_n;
	logic               push;
	logic               full;
	ttw_in_t            in_word;
	logic               empty;
	logic               pop;
	ttw_out_t           out_word;
	logic               text_color_we;
	logic [COLOR_W-1:0] text_color;

	int pending;
	int mismatches;
	int words_sent;
	int words_taken;
	int cycles;

	text_mode_terminal_writer DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.in_word      (in_word),
		.empty        (empty),
		.pop          (pop),
		.out_word     (out_word),
		.text_color_we(text_color_we),
		.text_color   (text_color)
	);

	terminal_screen_checker checker_inst (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.in_word      (in_word),
		.empty        (empty),
		.pop          (pop),
		.out_word     (out_word),
		.text_color_we(text_color_we),
		.text_color   (text_color),
		.pending      (pending),
		.mismatches   (mismatches)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Timeout guard.
	initial begin
		for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) begin
			@(posedge clk);
		end
		$display("simulation failed");
		$finish;
	end

	// Result side: random stalls, a stretch without stalls now and then, and one long hold-off
	// that lets the block fill up and push back on the sender.
	initial begin : result_sink
		int gap;
		pop = 1'b0;
		words_taken = 0;
		wait (arst_n === 1'b1);
		forever begin
			gap = $urandom_range(0, MAX_GAP);
			if ((words_taken / 64) % 5 == 4) begin
				gap = 0;
			end
			if (words_taken == HOLD_AT) begin
				gap = HOLD_CYCLES;
			end
			@(negedge clk);
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			words_taken++;
		end
	end

	// Offers one word after a random gap and returns once it has been accepted.
	// push stays high on return so back-to-back words need no extra edge.
	task automatic send_word(input ttw_in_t w);
		int gap;
		gap = $urandom_range(0, MAX_GAP);
		if ((words_sent / 64) % 5 == 2) begin
			gap = 0;
		end
		@(negedge clk);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push <= 1'b1;
		in_word <= w;
		do @(posedge clk); while (full);
		words_sent++;
	endtask

	// A word with the given command and random contents in the other fields.
	function automatic ttw_in_t any_word(input logic [CMD_W-1:0] cmd);
		ttw_in_t w;
		w.command = cmd;
		w.char_code = CHAR_W'($urandom);
		w.cell_index = IDX_W'($urandom);
		return w;
	endfunction

	task automatic send_put(input logic [CHAR_W-1:0] ch);
		ttw_in_t w;
		w = any_word(CMD_PUT);
		w.char_code = ch;
		send_word(w);
	endtask

	task automatic send_read(input logic [IDX_W-1:0] idx);
		ttw_in_t w;
		w = any_word(CMD_READ);
		w.cell_index = idx;
		send_word(w);
	endtask

	// Stops offering words and waits until every result has come back.
	task automatic wait_idle();
		@(negedge clk);
		push <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_text_color(input logic [COLOR_W-1:0] color);
		wait_idle();
		text_color_we <= 1'b1;
		text_color <= color;
		@(negedge clk);
		text_color_we <= 1'b0;
	endtask

	// Mostly lines of text of random length, often longer than a row, with reads,
	// backspaces and spare commands mixed in; now and then newline runs that scroll
	// repeatedly, clears and backspace runs.
	task automatic random_phase(input int n);
		int stop;
		int len;
		int r;
		stop = words_sent + n;
		while (words_sent < stop) begin
			r = $urandom_range(0, 99);
			if (r < 88) begin
				len = $urandom_range(0, 100);
				for (int i = 0; i < len; i++) begin
					r = $urandom_range(0, 99);
					if (r < 12) begin
						if ($urandom_range(0, 9) == 0) begin
							send_read(IDX_W'($urandom_range(CELLS, 2 ** IDX_W - 1)));
						end else begin
							send_read(IDX_W'($urandom_range(0, CELLS - 1)));
						end
					end else if (r < 16) begin
						send_put(CH_BACKSPACE);
					end else if (r < 18) begin
						send_word(any_word(CMD_SPARE));
					end else if (r < 90) begin
						send_put(CHAR_W'($urandom_range(8'h20, 8'h7E)));
					end else begin
						send_put(CHAR_W'($urandom));
					end
				end
				if ($urandom_range(0, 99) < 85) begin
					send_put(CH_NEWLINE);
				end
			end else if (r < 93) begin
				repeat ($urandom_range(1, 28)) send_put(CH_NEWLINE);
			end else if (r < 97) begin
				send_word(any_word(CMD_CLEAR));
				repeat ($urandom_range(0, 3)) send_put(CH_BACKSPACE);
			end else begin
				repeat ($urandom_range(1, 6)) send_put(CH_BACKSPACE);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		in_word = '0;
		text_color_we = 1'b0;
		text_color = COLOR_RESET;
		words_sent = 0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// Directed words: only cells already written are read before the first clear.
		send_put(8'h41);
		send_read(IDX_W'(0));
		send_put(CH_BACKSPACE);
		send_put(CH_BACKSPACE);
		send_read(IDX_W'(0));
		send_word(any_word(CMD_CLEAR));
		send_read(IDX_W'(CELLS - 1));
		send_read(IDX_W'(CELLS));
		send_read({IDX_W{1'b1}});
		send_put({CHAR_W{1'b1}});
		send_put({CHAR_W{1'b0}});
		send_put(8'h80);
		send_read(IDX_W'(0));
		send_read(IDX_W'(1));
		send_read(IDX_W'(2));
		send_put(CH_NEWLINE);
		// Backspace at column 0 wraps to the last column of the row above.
		send_put(CH_BACKSPACE);
		send_read(IDX_W'(COLUMNS - 1));
		send_word('{command: CMD_SPARE, char_code: {CHAR_W{1'b1}},
			cell_index: {IDX_W{1'b1}}});
		send_word('{command: CMD_SPARE, char_code: '0, cell_index: '0});

		// Random phases, each under its own text color.
		set_text_color('0);
		random_phase(PHASE_WORDS);
		set_text_color('1);
		random_phase(PHASE_WORDS);
		set_text_color(COLOR_W'($urandom_range(1, 254)));
		random_phase(PHASE_WORDS);
		set_text_color(COLOR_W'($urandom));
		random_phase(PHASE_WORDS);

		wait_idle();
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
